@@ rtl/core/tmdc_pkg.sv @@
// shared constants, types and helpers for the two-means dominant centroid block
package tmdc_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 32;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ACC_W      = COORD_W + CNT_W;
    localparam int DIST_W     = 64;
    localparam int ITER_W     = 4;
    localparam int SC_W       = 4;

    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(10);

    // per-point step numbers
    localparam logic [SC_W-1:0] SC_READ     = SC_W'(0);
    localparam logic [SC_W-1:0] SC_FEAT_A   = SC_W'(1);
    localparam logic [SC_W-1:0] SC_FEAT_A3  = SC_W'(4);
    localparam logic [SC_W-1:0] SC_FEAT_B   = SC_W'(5);
    localparam logic [SC_W-1:0] SC_FEAT_B3  = SC_W'(8);
    localparam logic [SC_W-1:0] SC_SEED_USE = SC_W'(7);
    localparam logic [SC_W-1:0] SC_ASGN_USE = SC_W'(11);
    localparam logic [SC_W-1:0] SC_WAIT     = SC_W'(1);

    typedef enum logic [1:0] {
        CSEL_CUR = 2'd0,
        CSEL_C0  = 2'd1,
        CSEL_C1  = 2'd2
    } csel_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MEAN  = 8'b0000_0010,
        S_MDIV  = 8'b0000_0100,
        S_SEED  = 8'b0000_1000,
        S_SLOAD = 8'b0001_0000,
        S_ASGN  = 8'b0010_0000,
        S_RDIV  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic             load;
        logic             short_out;
        logic             rd;
        logic             rd_best;
        logic [IDX_W-1:0] addr;
        logic             mean_clr;
        logic             mean_acc;
        logic             dist_clr;
        logic             dist_go;
        logic [1:0]       feat;
        csel_t            csel;
        logic             dsel;
        logic             seed_clr;
        logic             seed_first;
        logic             seed_upd;
        logic             cen_load;
        logic             asgn_clr;
        logic             asgn_upd;
        logic             div_start;
        logic             div_bank;
        logic             div_by_n;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic             enough;
        logic             out_busy;
        logic [CNT_W-1:0] n;
        logic [1:0]       size_nz;
        logic             div_done;
    } sts_t;

    function automatic logic [COORD_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return COORD_W'(t);
    endfunction

endpackage

@@ rtl/core/two_means_dominant_centroid.sv @@
// top level of the two-means dominant centroid block
//
//  channel   direction  handshake              carries
//  point     in         in_valid / in_ready    point_x/y/z/radius, last_point
//  centroid  out        out_valid / out_ready  center_x/y/z, found, overflowed
//  config    in         cfg_we (no wait)       cfg_wdata = iteration_count
//
// points load one per cycle; a request with last_point closes the set
// compute time for n points is set by the per-point distance pipe
// and the bit-serial 41-step divider
// in_ready is low while a set is being computed and while a result is stalled
// reset clears control, counts and sets iteration_count to 10; the stores are not cleared
// a stalled result holds in its register; the next set loads once it is taken
module two_means_dominant_centroid import tmdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic [COORD_W-1:0] point_radius,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] center_x,
    output logic [COORD_W-1:0] center_y,
    output logic [COORD_W-1:0] center_z,
    output logic               found,
    output logic               overflowed,
    input  logic               cfg_we,
    input  logic [ITER_W-1:0]  cfg_wdata
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: owns the state machine, loop counters and round count register
    tmdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .in_ready   (in_ready),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: point store, distance pipe, accumulators, divider, result register
    tmdc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .point_radius (point_radius),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .found        (found),
        .overflowed   (overflowed)
    );

endmodule

@@ rtl/core/tmdc_div.sv @@
// restoring signed-by-unsigned divider, one quotient bit per cycle
module tmdc_div import tmdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic [COORD_W-1:0]      quot
);

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ACC_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, mag_reg[ACC_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(ACC_W);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= (dividend < 0) ? ACC_W'(-dividend) : ACC_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend < 0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[ACC_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (-mag_reg[COORD_W-1:0]) : mag_reg[COORD_W-1:0];

endmodule

@@ rtl/core/tmdc_dpath.sv @@
// datapath: point store, distance pipe, accumulators, centres and result register
module tmdc_dpath import tmdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic [COORD_W-1:0] point_radius,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [COORD_W-1:0] center_x,
    output logic [COORD_W-1:0] center_y,
    output logic [COORD_W-1:0] center_z,
    output logic               found,
    output logic               overflowed
);

    logic [3:0][COORD_W-1:0] pt_mem [MAX_POINTS];
    logic [DIST_W-1:0]       nsd_mem [MAX_POINTS];

    logic [3:0][COORD_W-1:0] pt_q_reg;
    logic [DIST_W-1:0]       nsd_q_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic                    out_valid_reg, out_valid_next;

    logic [3:0][COORD_W-1:0] cur_reg, c0_reg, c1_reg;
    logic signed [ACC_W-1:0] acc_reg [2][4];
    logic [CNT_W-1:0]        size_reg [2];
    logic [DIST_W-1:0]       dist_reg [2];
    logic [DIST_W-1:0]       best_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    logic [COORD_W-1:0]      s1_abs_reg;
    logic                    s1_v_reg, s1_d_reg;
    logic [DIST_W-1:0]       s2_sq_reg;
    logic                    s2_v_reg, s2_d_reg;

    logic [COORD_W-1:0]      out_x_reg, out_y_reg, out_z_reg;
    logic                    found_reg, ovfo_reg;

    logic                    store_ok;
    logic [IDX_W-1:0]        rd_addr;
    logic [3:0][COORD_W-1:0] cen_sel;
    logic signed [COORD_W:0] diff;
    logic [DIST_W:0]         sum_wide;
    logic [DIST_W-1:0]       nd;
    logic                    k;
    logic                    div_done;
    logic [COORD_W-1:0]      div_q;
    logic signed [ACC_W-1:0] div_dvd;
    logic [CNT_W-1:0]        div_dvs;

    assign store_ok = cnt_reg < CNT_W'(MAX_POINTS);
    assign rd_addr  = cmd.rd_best ? best_idx_reg : cmd.addr;

    // point store and nearest-seed store
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            pt_mem[cnt_reg[IDX_W-1:0]] <= {sext_coord(point_radius), sext_coord(point_z),
                                           sext_coord(point_y), sext_coord(point_x)};
        end
        if (cmd.rd)
        begin
            pt_q_reg <= pt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_upd)
        begin
            nsd_mem[cmd.addr] <= nd;
        end
        if (cmd.rd)
        begin
            nsd_q_reg <= nsd_mem[rd_addr];
        end
    end

    // set bookkeeping and result handshake
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cmd.load)
        begin
            if (store_ok)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.short_out || cmd.out_load)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.short_out || cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.short_out)
        begin
            out_x_reg <= '0;
            out_y_reg <= '0;
            out_z_reg <= '0;
            found_reg <= 1'b0;
            ovfo_reg  <= ovf_reg;
        end
        else if (cmd.out_load)
        begin
            if (size_reg[0] > size_reg[1])
            begin
                out_x_reg <= c0_reg[0];
                out_y_reg <= c0_reg[1];
                out_z_reg <= c0_reg[2];
            end
            else
            begin
                out_x_reg <= c1_reg[0];
                out_y_reg <= c1_reg[1];
                out_z_reg <= c1_reg[2];
            end
            found_reg <= 1'b1;
            ovfo_reg  <= ovf_reg;
        end
    end

    // squared distance pipe: abs diff, square, saturating sum
    always_comb
    begin
        unique case (cmd.csel)
            CSEL_CUR: cen_sel = cur_reg;
            CSEL_C0:  cen_sel = c0_reg;
            CSEL_C1:  cen_sel = c1_reg;
            default:  cen_sel = cur_reg;
        endcase
        diff     = (COORD_W+1)'(signed'(pt_q_reg[cmd.feat]))
                 - (COORD_W+1)'(signed'(cen_sel[cmd.feat]));
        sum_wide = {1'b0, dist_reg[s2_d_reg]} + {1'b0, s2_sq_reg};
        nd       = (cmd.seed_first || (dist_reg[0] < nsd_q_reg)) ? dist_reg[0] : nsd_q_reg;
        k        = dist_reg[1] < dist_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.dist_go;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_abs_reg <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        s1_d_reg   <= cmd.dsel;
        s2_sq_reg  <= DIST_W'(s1_abs_reg) * DIST_W'(s1_abs_reg);
        s2_d_reg   <= s1_d_reg;
        if (cmd.dist_clr)
        begin
            dist_reg[0] <= '0;
            dist_reg[1] <= '0;
        end
        else if (s2_v_reg)
        begin
            dist_reg[s2_d_reg] <= sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];
        end
    end

    // farthest-point bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.seed_clr)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (cmd.seed_upd && (nd > best_reg))
        begin
            best_reg     <= nd;
            best_idx_reg <= cmd.addr;
        end
    end

    // accumulators and cluster sizes
    always_ff @(posedge clk)
    begin
        if (cmd.mean_clr || cmd.asgn_clr)
        begin
            for (int f = 0; f < 4; f++)
            begin
                acc_reg[0][f] <= '0;
                acc_reg[1][f] <= '0;
            end
            size_reg[0] <= '0;
            size_reg[1] <= '0;
        end
        else if (cmd.mean_acc)
        begin
            for (int f = 0; f < 4; f++)
            begin
                acc_reg[0][f] <= acc_reg[0][f] + ACC_W'(signed'(pt_q_reg[f]));
            end
        end
        else if (cmd.asgn_upd)
        begin
            for (int f = 0; f < 4; f++)
            begin
                acc_reg[k][f] <= acc_reg[k][f] + ACC_W'(signed'(pt_q_reg[f]));
            end
            size_reg[k] <= size_reg[k] + CNT_W'(1);
        end
    end

    // centres
    always_ff @(posedge clk)
    begin
        if (cmd.cen_load)
        begin
            cur_reg <= pt_q_reg;
            if (cmd.csel == CSEL_C0)
            begin
                c0_reg <= pt_q_reg;
            end
            if (cmd.csel == CSEL_C1)
            begin
                c1_reg <= pt_q_reg;
            end
        end
        else if (div_done)
        begin
            unique case (cmd.csel)
                CSEL_CUR: cur_reg[cmd.feat] <= div_q;
                CSEL_C0:  c0_reg[cmd.feat]  <= div_q;
                CSEL_C1:  c1_reg[cmd.feat]  <= div_q;
                default:  cur_reg[cmd.feat] <= div_q;
            endcase
        end
    end

    assign div_dvd = acc_reg[cmd.div_bank][cmd.feat];
    assign div_dvs = cmd.div_by_n ? cnt_reg : size_reg[cmd.div_bank];

    tmdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q)
    );

    assign sts.enough   = cnt_reg != '0;
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign sts.n        = cnt_reg;
    assign sts.size_nz  = {size_reg[1] != '0, size_reg[0] != '0};
    assign sts.div_done = div_done;

    assign out_valid  = out_valid_reg;
    assign center_x   = out_x_reg;
    assign center_y   = out_y_reg;
    assign center_z   = out_z_reg;
    assign found      = found_reg;
    assign overflowed = ovfo_reg;

endmodule

@@ rtl/core/tmdc_ctrl.sv @@
// controller: sequences loading, mean, seeding, lloyd rounds and result
module tmdc_ctrl import tmdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_point,
    output logic              in_ready,
    input  logic              cfg_we,
    input  logic [ITER_W-1:0] cfg_wdata,
    input  sts_t              sts,
    output cmd_t              cmd
);

    state_t            state_reg, state_next;
    logic [SC_W-1:0]   sc_reg, sc_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [1:0]        f_reg, f_next;
    logic              s_reg, s_next;
    logic              k_reg, k_next;
    logic [ITER_W-1:0] r_reg, r_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic              accept;
    logic              last_i;
    logic [ITER_W-1:0] rounds_m1;
    csel_t             k_csel;

    assign last_i    = (CNT_W'(i_reg) + CNT_W'(1)) == sts.n;
    assign rounds_m1 = (iter_reg == '0) ? '0 : iter_reg - ITER_W'(1);
    assign k_csel    = k_reg ? CSEL_C1 : CSEL_C0;
    assign in_ready  = (state_reg == S_IDLE) && !sts.out_busy;
    assign accept    = in_valid && in_ready;
    assign iter_next = cfg_we ? cfg_wdata : iter_reg;

    always_comb
    begin
        state_next = state_reg;
        sc_next    = sc_reg;
        i_next     = i_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        cmd        = '0;
        cmd.addr   = i_reg;
        cmd.feat   = f_reg;
        cmd.csel   = CSEL_CUR;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept && last_point)
                begin
                    if (sts.enough)
                    begin
                        cmd.mean_clr = 1'b1;
                        state_next   = S_MEAN;
                        i_next       = '0;
                        sc_next      = SC_READ;
                    end
                    else
                    begin
                        cmd.short_out = 1'b1;
                    end
                end
            end
            S_MEAN:
            begin
                if (sc_reg == SC_READ)
                begin
                    cmd.rd  = 1'b1;
                    sc_next = SC_WAIT;
                end
                else
                begin
                    cmd.mean_acc = 1'b1;
                    sc_next      = SC_READ;
                    if (last_i)
                    begin
                        state_next = S_MDIV;
                        f_next     = '0;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            S_MDIV:
            begin
                cmd.div_by_n = 1'b1;
                if (sc_reg == SC_READ)
                begin
                    cmd.div_start = 1'b1;
                    sc_next       = SC_WAIT;
                end
                else if (sts.div_done)
                begin
                    sc_next = SC_READ;
                    if (f_reg == 2'd3)
                    begin
                        state_next   = S_SEED;
                        s_next       = 1'b0;
                        i_next       = '0;
                        cmd.seed_clr = 1'b1;
                    end
                    else
                    begin
                        f_next = f_reg + 2'd1;
                    end
                end
            end
            S_SEED:
            begin
                cmd.feat       = 2'(sc_reg - SC_FEAT_A);
                cmd.seed_first = !s_reg;
                cmd.rd         = sc_reg == SC_READ;
                cmd.dist_clr   = sc_reg == SC_FEAT_A;
                cmd.dist_go    = (sc_reg >= SC_FEAT_A) && (sc_reg <= SC_FEAT_A3);
                sc_next        = sc_reg + SC_W'(1);
                if (sc_reg == SC_SEED_USE)
                begin
                    cmd.seed_upd = 1'b1;
                    sc_next      = SC_READ;
                    if (last_i)
                    begin
                        state_next = S_SLOAD;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            S_SLOAD:
            begin
                cmd.csel = s_reg ? CSEL_C1 : CSEL_C0;
                if (sc_reg == SC_READ)
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_best = 1'b1;
                    sc_next     = SC_WAIT;
                end
                else
                begin
                    cmd.cen_load = 1'b1;
                    sc_next      = SC_READ;
                    i_next       = '0;
                    if (!s_reg)
                    begin
                        s_next       = 1'b1;
                        cmd.seed_clr = 1'b1;
                        state_next   = S_SEED;
                    end
                    else
                    begin
                        r_next       = '0;
                        cmd.asgn_clr = 1'b1;
                        state_next   = S_ASGN;
                    end
                end
            end
            S_ASGN:
            begin
                cmd.rd       = sc_reg == SC_READ;
                cmd.dist_clr = sc_reg == SC_FEAT_A;
                if ((sc_reg >= SC_FEAT_A) && (sc_reg <= SC_FEAT_A3))
                begin
                    cmd.dist_go = 1'b1;
                    cmd.feat    = 2'(sc_reg - SC_FEAT_A);
                    cmd.csel    = CSEL_C0;
                end
                if ((sc_reg >= SC_FEAT_B) && (sc_reg <= SC_FEAT_B3))
                begin
                    cmd.dist_go = 1'b1;
                    cmd.feat    = 2'(sc_reg - SC_FEAT_B);
                    cmd.csel    = CSEL_C1;
                    cmd.dsel    = 1'b1;
                end
                sc_next = sc_reg + SC_W'(1);
                if (sc_reg == SC_ASGN_USE)
                begin
                    cmd.asgn_upd = 1'b1;
                    sc_next      = SC_READ;
                    if (last_i)
                    begin
                        state_next = S_RDIV;
                        k_next     = 1'b0;
                        f_next     = '0;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            S_RDIV:
            begin
                cmd.csel     = k_csel;
                cmd.div_bank = k_reg;
                cmd.addr     = '0;
                if (!sts.size_nz[k_reg])
                begin
                    // empty cluster takes the first stored point
                    if (sc_reg == SC_READ)
                    begin
                        cmd.rd  = 1'b1;
                        sc_next = SC_WAIT;
                    end
                    else
                    begin
                        cmd.cen_load = 1'b1;
                        sc_next      = SC_READ;
                        f_next       = 2'd3;
                    end
                end
                else if (sc_reg == SC_READ)
                begin
                    cmd.div_start = 1'b1;
                    sc_next       = SC_WAIT;
                end
                else if (sts.div_done)
                begin
                    sc_next = SC_READ;
                    f_next  = f_reg + 2'd1;
                end
                if ((f_next == 2'd3 && !sts.size_nz[k_reg] && sc_reg == SC_WAIT)
                    || (sts.size_nz[k_reg] && sts.div_done && f_reg == 2'd3))
                begin
                    f_next = '0;
                    if (!k_reg)
                    begin
                        k_next = 1'b1;
                    end
                    else if (r_reg == rounds_m1)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        r_next       = r_reg + ITER_W'(1);
                        i_next       = '0;
                        cmd.asgn_clr = 1'b1;
                        state_next   = S_ASGN;
                    end
                end
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg    <= '0;
            i_reg     <= '0;
            f_reg     <= '0;
            s_reg     <= 1'b0;
            k_reg     <= 1'b0;
            r_reg     <= '0;
            iter_reg  <= ITER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            i_reg     <= i_next;
            f_reg     <= f_next;
            s_reg     <= s_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            iter_reg  <= iter_next;
        end
    end

    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.div_start)
        else $error("divider restarted back to back");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result written over a pending result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("point stored while computing");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> ((state_reg == S_MDIV) || (state_reg == S_RDIV)))
        else $error("division finished outside a divide phase");

endmodule
